>>> hw/rtl/qam_pkg.sv
`timescale 1ns / 1ps
// qam_pkg: shared widths and defaults for the quaternion to affine matrix block.
// No dependencies.
package qam_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QUAT_W        = 18;
	localparam int OFS_W         = 32;
	localparam int SIZE_W        = 24;
	localparam int OUT_W         = 32;
	localparam int N_ROT         = 9;
	localparam int N_OUT         = 12;
	localparam int S_TDATA_W     = 224;
	localparam int M_TDATA_W     = N_OUT * OUT_W;

endpackage

>>> hw/rtl/qam_isqrt.sv
`timescale 1ns / 1ps
// qam_isqrt: pipelined integer square root, one result bit per stage.
// Stand-alone; side data travels alongside the value.
module qam_isqrt #(
	parameter int VW = 37,
	parameter int RW = 19,
	parameter int DW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [VW-1:0] in_val,
	input  logic [DW-1:0] in_side,
	output logic          out_valid,
	output logic [RW-1:0] out_root,
	output logic [DW-1:0] out_side
);

	logic [VW-1:0] rem_s  [RW];
	logic [VW-1:0] root_s [RW];
	logic [DW-1:0] side_s [RW];
	logic          valid_s[RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam logic [VW:0] BIT = (VW+1)'(1) << (2 * (RW - 1 - k));
		logic [VW-1:0] rem_i;
		logic [VW-1:0] root_i;
		logic [DW-1:0] side_i;
		logic          valid_i;
		logic [VW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_i   = in_val;
			assign root_i  = '0;
			assign side_i  = in_side;
			assign valid_i = in_valid;
		end else begin : g_next
			assign rem_i   = rem_s[k-1];
			assign root_i  = root_s[k-1];
			assign side_i  = side_s[k-1];
			assign valid_i = valid_s[k-1];
		end

		assign trial = {1'b0, root_i} + BIT;
		assign ge    = {1'b0, rem_i} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? VW'({1'b0, rem_i} - trial) : rem_i;
				root_s[k] <= ge ? VW'(({1'b0, root_i} >> 1) + BIT) : (root_i >> 1);
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = valid_s[RW-1];
	assign out_root  = root_s[RW-1][RW-1:0];
	assign out_side  = side_s[RW-1];

endmodule

>>> hw/rtl/qam_div.sv
`timescale 1ns / 1ps
// qam_div: three-lane pipelined restoring divider with a shared divisor.
// One quotient bit per stage; stand-alone.
module qam_div #(
	parameter int NW = 35,
	parameter int QW = 18,
	parameter int RW = 19,
	parameter int DW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2:0][NW-1:0]   in_num,
	input  logic [RW-1:0]        in_den,
	input  logic [DW-1:0]        in_side,
	output logic                 out_valid,
	output logic [2:0][QW-1:0]   out_quo,
	output logic [DW-1:0]        out_side
);

	logic [2:0][RW-1:0] rem_s  [QW];
	logic [2:0][QW-1:0] nq_s   [QW];
	logic [RW-1:0]      den_s  [QW];
	logic [DW-1:0]      side_s [QW];
	logic               valid_s[QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [2:0][RW-1:0] rem_i;
		logic [2:0][QW-1:0] nq_i;
		logic [RW-1:0]      den_i;
		logic [DW-1:0]      side_i;
		logic               valid_i;
		logic [2:0][RW-1:0] rem_n;
		logic [2:0][QW-1:0] nq_n;

		if (k == 0) begin : g_first
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rem_i[l] = RW'(in_num[l][NW-1:QW]);
				assign nq_i[l]  = in_num[l][QW-1:0];
			end
			assign den_i   = in_den;
			assign side_i  = in_side;
			assign valid_i = in_valid;
		end else begin : g_next
			assign rem_i   = rem_s[k-1];
			assign nq_i    = nq_s[k-1];
			assign den_i   = den_s[k-1];
			assign side_i  = side_s[k-1];
			assign valid_i = valid_s[k-1];
		end

		for (genvar l = 0; l < 3; l++) begin : g_step
			logic [RW:0] sh;
			logic        ge;
			assign sh       = {rem_i[l], nq_i[l][QW-1]};
			assign ge       = sh >= {1'b0, den_i};
			assign rem_n[l] = ge ? RW'(sh - {1'b0, den_i}) : sh[RW-1:0];
			assign nq_n[l]  = {nq_i[l][QW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_n;
				nq_s[k]   <= nq_n;
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = valid_s[QW-1];
	assign out_quo   = nq_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

>>> hw/rtl/quaternion_to_affine_matrix_top.sv
`timescale 1ns / 1ps
// Quaternion to affine matrix, fixed point. Uses qam_pkg, qam_isqrt, qam_div.
// Root width RW = (max(2F,36)+2)/2 and quotient width QW = F+2.
// Throughput: one request per cycle; the whole pipeline halts while the output
// is valid and not taken. Depth is set by the square root and divider stages.
// Reset: arst_n clears all valid bits; data registers are not reset.
module quaternion_to_affine_matrix_top #(
	parameter int FRAC_BITS = qam_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// quat_b, quat_c, quat_d, offset_x, offset_y, offset_z, size_x, size_y, size_z, pad
	input  logic [qam_pkg::S_TDATA_W-1:0]  s_tdata,
	// flip_z
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// r00, r01, r02, t0, r10, r11, r12, t1, r20, r21, r22, t2
	output logic [qam_pkg::M_TDATA_W-1:0]  m_tdata
);
	import qam_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int VW  = ((2 * F > 36) ? 2 * F : 36) + 1;
	localparam int RW  = (VW + 1) / 2;
	localparam int QW  = F + 2;
	localparam int NW  = QUAT_W + F + 1;
	localparam int CW  = (F + 2 > QUAT_W) ? F + 2 : QUAT_W;
	localparam int ZW  = (F + 2 > SIZE_W + 1) ? F + 2 : SIZE_W + 1;
	localparam int PW  = 2 * CW;
	localparam int TW  = PW + 3;
	localparam int TRW = TW - F + 1;
	localparam int MW  = TRW + ZW;
	localparam int FW  = MW - F + 1;
	localparam int BW  = 3 * QUAT_W;
	localparam int ZSW = 3 * ZW;
	localparam int OW  = 3 * OFS_W;
	localparam int RSW = ZSW + OW;
	localparam int SDW = BW + RSW + 1;
	localparam int DDW = SDW + RW;

	localparam logic [VW:0]        ONE_SQ   = (VW+1)'(1) << (2 * F);
	localparam longint             THRESH_L = ((longint'(1) << (2 * F)) + 64'sd5000000)
	                                          / 64'sd10000000;
	localparam logic signed [VW:0] THRESH   = (VW+1)'(THRESH_L);
	localparam logic [TW-1:0]      HALF_T   = TW'(1) << (F - 1);
	localparam logic [MW-1:0]      HALF_M   = MW'(1) << (F - 1);
	localparam logic signed [FW-1:0] SAT_HI = FW'(64'sh7FFF_FFFF);
	localparam logic signed [FW-1:0] SAT_LO = -FW'(64'sh8000_0000);

	function automatic logic signed [ZW-1:0] eff_size(input logic signed [SIZE_W-1:0] v);
		if (v > 0) begin
			return ZW'(v);
		end
		return ZW'(1) << F;
	endfunction

	function automatic logic signed [TRW-1:0] rnd_t(input logic signed [TW-1:0] v);
		logic [TW-1:0] m;
		logic [TW-1:0] q;
		m = v[TW-1] ? TW'(-v) : TW'(v);
		q = (m + HALF_T) >> F;
		return v[TW-1] ? -TRW'(q) : TRW'(q);
	endfunction

	function automatic logic signed [FW-1:0] rnd_m(input logic signed [MW-1:0] v);
		logic [MW-1:0] m;
		logic [MW-1:0] q;
		m = v[MW-1] ? MW'(-v) : MW'(v);
		q = (m + HALF_M) >> F;
		return v[MW-1] ? -FW'(q) : FW'(q);
	endfunction

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// input unpack
	logic signed [QUAT_W-1:0] in_q[3];
	logic signed [ZW-1:0]     in_z[3];
	logic [OW-1:0]            in_ofs;
	logic signed [SIZE_W-1:0] raw_z[3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_q[i]  = s_tdata[i*QUAT_W +: QUAT_W];
			raw_z[i] = s_tdata[BW + OW + i*SIZE_W +: SIZE_W];
			in_z[i]  = eff_size(raw_z[i]);
		end
		if (s_tuser[0]) begin
			in_z[2] = -in_z[2];
		end
		in_ofs = s_tdata[BW +: OW];
	end

	// s1: squares
	logic                       valid_s1;
	logic [2*QUAT_W-1:0]        sq_s1[3];
	logic [BW-1:0]              q_s1;
	logic [RSW-1:0]             rest_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= (2*QUAT_W)'(in_q[i] * in_q[i]);
			end
			q_s1    <= s_tdata[BW-1:0];
			rest_s1 <= {in_ofs, in_z[2], in_z[1], in_z[0]};
		end
	end

	// s2: sum of squares, a^2 and path choice
	logic [VW-1:0]        ssum;
	logic signed [VW:0]   a2;
	logic                 small_n;
	logic                 valid_s2;
	logic [VW-1:0]        op_s2;
	logic [SDW-1:0]       side_s2;

	assign ssum    = VW'(sq_s1[0]) + VW'(sq_s1[1]) + VW'(sq_s1[2]);
	assign a2      = ONE_SQ - {1'b0, ssum};
	assign small_n = a2 < THRESH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= small_n ? ssum : a2[VW-1:0];
			side_s2 <= {small_n, rest_s1, q_s1};
		end
	end

	// square root
	logic           sq_valid;
	logic [RW-1:0]  sq_root;
	logic [SDW-1:0] sq_side;

	qam_isqrt #(.VW(VW), .RW(RW), .DW(SDW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s2),
		.in_val   (op_s2),
		.in_side  (side_s2),
		.out_valid(sq_valid),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// divider feed: (|x| << F + r/2) / r
	logic [RW-1:0]        den;
	logic [2:0][NW-1:0]   num;

	assign den = (sq_root == '0) ? RW'(1) : sq_root;

	always_comb begin
		logic signed [QUAT_W-1:0] x;
		logic [QUAT_W-1:0]        mag;
		for (int l = 0; l < 3; l++) begin
			x      = sq_side[l*QUAT_W +: QUAT_W];
			mag    = x[QUAT_W-1] ? QUAT_W'(-x) : QUAT_W'(x);
			num[l] = (NW'(mag) << F) + NW'(den >> 1);
		end
	end

	logic               dv_valid;
	logic [2:0][QW-1:0] dv_quo;
	logic [DDW-1:0]     dv_side;

	qam_div #(.NW(NW), .QW(QW), .RW(RW), .DW(DDW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.in_num   (num),
		.in_den   (den),
		.in_side  ({sq_root, sq_side}),
		.out_valid(dv_valid),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	// s3: component select and products
	logic signed [CW-1:0] ca, cq[3];
	logic                 dv_small;
	logic [RW-1:0]        dv_root;

	assign dv_small = dv_side[SDW-1];
	assign dv_root  = dv_side[SDW +: RW];

	always_comb begin
		logic signed [QUAT_W-1:0] x;
		ca = dv_small ? '0 : CW'(dv_root);
		for (int l = 0; l < 3; l++) begin
			x = dv_side[l*QUAT_W +: QUAT_W];
			if (dv_small) begin
				cq[l] = x[QUAT_W-1] ? -CW'(dv_quo[l]) : CW'(dv_quo[l]);
			end else begin
				cq[l] = CW'(x);
			end
		end
	end

	logic                 valid_s3;
	logic signed [PW-1:0] aa_s3, bb_s3, cc_s3, dd_s3, ab_s3, ac_s3, ad_s3, bc_s3, bd_s3, cd_s3;
	logic [RSW-1:0]       rest_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s3   <= ca * ca;
			bb_s3   <= cq[0] * cq[0];
			cc_s3   <= cq[1] * cq[1];
			dd_s3   <= cq[2] * cq[2];
			ab_s3   <= ca * cq[0];
			ac_s3   <= ca * cq[1];
			ad_s3   <= ca * cq[2];
			bc_s3   <= cq[0] * cq[1];
			bd_s3   <= cq[0] * cq[2];
			cd_s3   <= cq[1] * cq[2];
			rest_s3 <= dv_side[BW +: RSW];
		end
	end

	// s4: rotation terms at scale 2^(2F)
	logic                 valid_s4;
	logic signed [TW-1:0] term_s4[N_ROT];
	logic [RSW-1:0]       rest_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			term_s4[0] <= TW'(aa_s3) + TW'(bb_s3) - TW'(cc_s3) - TW'(dd_s3);
			term_s4[1] <= (TW'(bc_s3) - TW'(ad_s3)) <<< 1;
			term_s4[2] <= (TW'(bd_s3) + TW'(ac_s3)) <<< 1;
			term_s4[3] <= (TW'(bc_s3) + TW'(ad_s3)) <<< 1;
			term_s4[4] <= TW'(aa_s3) + TW'(cc_s3) - TW'(bb_s3) - TW'(dd_s3);
			term_s4[5] <= (TW'(cd_s3) - TW'(ab_s3)) <<< 1;
			term_s4[6] <= (TW'(bd_s3) - TW'(ac_s3)) <<< 1;
			term_s4[7] <= (TW'(cd_s3) + TW'(ab_s3)) <<< 1;
			term_s4[8] <= TW'(aa_s3) + TW'(dd_s3) - TW'(cc_s3) - TW'(bb_s3);
			rest_s4    <= rest_s3;
		end
	end

	// s5: first rounding
	logic                  valid_s5;
	logic signed [TRW-1:0] t_s5[N_ROT];
	logic [RSW-1:0]        rest_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_ROT; i++) begin
				t_s5[i] <= rnd_t(term_s4[i]);
			end
			rest_s5 <= rest_s4;
		end
	end

	// s6: column scale
	logic                 valid_s6;
	logic signed [MW-1:0] m_s6[N_ROT];
	logic [OW-1:0]        ofs_s6;
	logic signed [ZW-1:0] zc[3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			zc[i] = rest_s5[i*ZW +: ZW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_ROT; i++) begin
				m_s6[i] <= MW'(t_s5[i]) * MW'(zc[i % 3]);
			end
			ofs_s6 <= rest_s5[ZSW +: OW];
		end
	end

	// s7: second rounding, saturation, output register
	logic                 valid_s7;
	logic [OUT_W-1:0]     out_s7[N_OUT];
	logic signed [FW-1:0] fin[N_ROT];

	always_comb begin
		for (int i = 0; i < N_ROT; i++) begin
			fin[i] = rnd_m(m_s6[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if (fin[3*r+c] > SAT_HI) begin
						out_s7[4*r+c] <= SAT_HI[OUT_W-1:0];
					end else if (fin[3*r+c] < SAT_LO) begin
						out_s7[4*r+c] <= SAT_LO[OUT_W-1:0];
					end else begin
						out_s7[4*r+c] <= fin[3*r+c][OUT_W-1:0];
					end
				end
				out_s7[4*r+3] <= ofs_s6[r*OFS_W +: OFS_W];
			end
		end
	end

	assign m_tvalid = valid_s7;

	always_comb begin
		for (int i = 0; i < N_OUT; i++) begin
			m_tdata[i*OUT_W +: OUT_W] = out_s7[i];
		end
	end

endmodule

>>> hw/rtl/qam_checker.sv
`timescale 1ns / 1ps
// qam_checker: port-level checks on the top level, attached by bind.
// Uses qam_pkg for the output bus width.
module qam_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [qam_pkg::M_TDATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output request dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow pipeline advance");

	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tready))
		else $error("output appeared without pipeline advance");

endmodule

bind quaternion_to_affine_matrix_top qam_checker u_qam_checker (.*);
